>>> rtl/pcmfc_pkg.sv
// Shared types, register indexes and helper functions of the PCM sample
// format converter. No dependencies.
package pcmfc_pkg;

    typedef enum logic [2:0] {
        FMT_S16    = 3'd0,
        FMT_S24_3  = 3'd1,
        FMT_S24_RJ = 3'd2,
        FMT_S24_LJ = 3'd3,
        FMT_S32    = 3'd4,
        FMT_F32    = 3'd5,
        FMT_F64    = 3'd6,
        FMT_NONE   = 3'd7
    } t_fmt;

    localparam logic REG_DECODE_FMT = 1'b0;
    localparam logic REG_ENCODE_FMT = 1'b1;

    localparam logic REQ_DECODE = 1'b0;

    function automatic logic [3:0] fmt_size(input t_fmt f);
        logic [3:0] s;
        case (f)
            FMT_S16:   s = 4'd2;
            FMT_S24_3: s = 4'd3;
            FMT_F64:   s = 4'd8;
            FMT_NONE:  s = 4'd0;
            default:   s = 4'd4;
        endcase
        return s;
    endfunction

    // Count of leading zeros; the result for an all-zero word is not used.
    function automatic logic [4:0] lzc32(input logic [31:0] a);
        logic [4:0] n;
        logic       found;
        n     = '0;
        found = 1'b0;
        for (int i = 31; i >= 0; i--) begin
            if (!found) begin
                if (a[i]) begin
                    found = 1'b1;
                end else begin
                    n = n + 5'd1;
                end
            end
        end
        return n;
    endfunction

endpackage

>>> rtl/pcm_sample_format_converter.sv
// Top level of the PCM sample format converter: a four-stage pipeline that
// decodes packed sample bytes to binary64 and encodes binary64 to bytes.
// Depends on pcmfc_pkg.
//
// Usage: write decode_format (index 0) and encode_format (index 1) on the
// plain write port while the block is idle. Each input word carries a
// request type, sample bytes for a decode and a binary64 pattern for an
// encode. Every input word gives exactly one output word.
// o_valid rises once an accepted word has passed from stage one through stages two
// and three into the output register of stage four. One word enters every cycle while
// o_stall is low; throughput is one word per cycle through the four register stages.
// Stage one latches the format and prepares sign, magnitude and clamping,
// stage two counts leading zeros and forms the exact product by 2^n-1,
// stage three normalizes and rounds, stage four packs the output register.
// A synchronous active-low reset empties the pipeline and sets both formats
// to s16. When the receiver stalls, the output word holds and each stage
// keeps filling until the pipeline is full; o_stall then rises.
module pcm_sample_format_converter (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [0:0]  i_cfg_idx,
    input  logic [2:0]  i_cfg_wdata,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_req_type,
    input  logic [63:0] i_in_bytes,
    input  logic [63:0] i_in_value,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [63:0] o_out_value,
    output logic [63:0] o_out_bytes,
    output logic [3:0]  o_byte_count
);

    pcmfc_pkg::t_fmt r_dec_fmt, r_enc_fmt;

    logic en1, en2, en3, en4;

    // Stage 1.
    logic            r1_v, r1_req, r1_neg, r1_sgn, r1_nan;
    pcmfc_pkg::t_fmt r1_fmt;
    logic [63:0]     r1_data;
    logic [31:0]     r1_mag;
    logic [10:0]     r1_ebase, r1_e;
    logic [52:0]     r1_m;

    // Stage 2.
    logic            r2_v, r2_req, r2_neg, r2_sgn, r2_nan;
    pcmfc_pkg::t_fmt r2_fmt;
    logic [63:0]     r2_data;
    logic [31:0]     r2_mag;
    logic [10:0]     r2_ebase, r2_e;
    logic [52:0]     r2_m;
    logic [4:0]      r2_lz, r2_c, r2_n;
    logic [83:0]     r2_p;

    // Stage 3.
    logic            r3_v, r3_req, r3_sgn, r3_nan, r3_zero;
    pcmfc_pkg::t_fmt r3_fmt;
    logic [63:0]     r3_data, r3_dec;
    logic [53:0]     r3_rk;
    logic [11:0]     r3_sh;
    logic [31:0]     r3_f32;

    // Stage 4 (output).
    logic            r4_v, r4_req;
    logic [63:0]     r_out_value, r_out_bytes;
    logic [3:0]      r_byte_count;

    assign en4     = !r4_v || !i_stall;
    assign en3     = !r3_v || en4;
    assign en2     = !r2_v || en3;
    assign en1     = !r1_v || en2;
    assign o_stall = !en1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dec_fmt <= pcmfc_pkg::FMT_S16;
            r_enc_fmt <= pcmfc_pkg::FMT_S16;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                pcmfc_pkg::REG_DECODE_FMT: r_dec_fmt <= pcmfc_pkg::t_fmt'(i_cfg_wdata);
                pcmfc_pkg::REG_ENCODE_FMT: r_enc_fmt <= pcmfc_pkg::t_fmt'(i_cfg_wdata);
                default: ;
            endcase
        end
    end

    // Stage 1: sign and magnitude for integer decode, clamping for encode.
    pcmfc_pkg::t_fmt n1_fmt;
    logic [31:0]     n1_x, n1_mag;
    logic [10:0]     n1_ebase, n1_ve;
    logic [51:0]     n1_vf;
    logic            n1_nan, n1_big;
    logic [63:0]     n1_data;

    always_comb begin
        n1_fmt   = i_req_type ? r_enc_fmt : r_dec_fmt;
        n1_x     = {{16{i_in_bytes[15]}}, i_in_bytes[15:0]};
        n1_ebase = 11'd1039;
        case (r_dec_fmt)
            pcmfc_pkg::FMT_S24_3, pcmfc_pkg::FMT_S24_RJ: begin
                n1_x     = {{8{i_in_bytes[23]}}, i_in_bytes[23:0]};
                n1_ebase = 11'd1031;
            end
            pcmfc_pkg::FMT_S24_LJ: begin
                n1_x     = {{8{i_in_bytes[31]}}, i_in_bytes[31:8]};
                n1_ebase = 11'd1031;
            end
            pcmfc_pkg::FMT_S32: begin
                n1_x     = i_in_bytes[31:0];
                n1_ebase = 11'd1023;
            end
            default: ;
        endcase
        n1_mag = n1_x[31] ? (32'd0 - n1_x) : n1_x;

        n1_ve  = i_in_value[62:52];
        n1_vf  = i_in_value[51:0];
        n1_nan = (n1_ve == 11'h7FF) && (n1_vf != 52'd0);
        n1_big = i_in_value[62:0] > 63'h3FF0_0000_0000_0000;
        if (n1_big) begin
            n1_ve = 11'd1023;
            n1_vf = '0;
        end
        n1_data = i_req_type ? {i_in_value[63], n1_ve, n1_vf} : i_in_bytes;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
        end else if (en1) begin
            r1_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en1) begin
            r1_req   <= i_req_type;
            r1_fmt   <= n1_fmt;
            r1_data  <= n1_data;
            r1_neg   <= n1_x[31];
            r1_mag   <= n1_mag;
            r1_ebase <= n1_ebase;
            r1_sgn   <= i_in_value[63];
            r1_nan   <= n1_nan;
            r1_e     <= n1_ve;
            r1_m     <= {n1_ve != 11'd0, n1_vf};
        end
    end

    // Stage 2: leading zero counts and the exact product m * (2^n - 1).
    logic [4:0]  n2_n;
    logic [83:0] n2_mx;

    always_comb begin
        case (r1_fmt)
            pcmfc_pkg::FMT_S16: n2_n = 5'd15;
            pcmfc_pkg::FMT_S32: n2_n = 5'd31;
            default:            n2_n = 5'd23;
        endcase
        n2_mx = {31'd0, r1_m};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_v <= 1'b0;
        end else if (en2) begin
            r2_v <= r1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en2) begin
            r2_req   <= r1_req;
            r2_fmt   <= r1_fmt;
            r2_data  <= r1_data;
            r2_neg   <= r1_neg;
            r2_mag   <= r1_mag;
            r2_ebase <= r1_ebase;
            r2_sgn   <= r1_sgn;
            r2_nan   <= r1_nan;
            r2_e     <= r1_e;
            r2_m     <= r1_m;
            r2_lz    <= pcmfc_pkg::lzc32(r1_mag);
            r2_c     <= pcmfc_pkg::lzc32({r1_data[22:0], 9'd0}) + 5'd1;
            r2_n     <= n2_n;
            r2_p     <= (n2_mx << n2_n) - n2_mx;
        end
    end

    // Stage 3: normalize decoded values, round the product and the f32 result.
    logic [31:0] n3_norm;
    logic [63:0] n3_int, n3_wid, n3_dec;
    logic [7:0]  n3_we;
    logic [22:0] n3_wm;
    logic [4:0]  n3_d;
    logic [6:0]  n3_top;
    logic [83:0] n3_ps, n3_low;
    logic        n3_rnd;
    logic [53:0] n3_rk;
    logic [30:0] n3_fw, n3_fbase;
    logic [10:0] n3_fs;
    logic [5:0]  n3_s6;
    logic [53:0] n3_m54, n3_fsm, n3_flow;
    logic        n3_frnd;

    always_comb begin
        n3_norm = r2_mag << r2_lz;
        if (r2_mag == 32'd0) begin
            n3_int = '0;
        end else begin
            n3_int = {r2_neg, r2_ebase - {6'd0, r2_lz}, n3_norm[30:0], 21'd0};
        end

        n3_we = r2_data[30:23];
        n3_wm = r2_data[22:0];
        if (n3_we == 8'hFF) begin
            if (n3_wm == 23'd0) begin
                n3_wid = {r2_data[31], 11'h7FF, 52'd0};
            end else begin
                n3_wid = {r2_data[31], 12'hFFF, n3_wm[21:0], 29'd0};
            end
        end else if (n3_we == 8'd0) begin
            if (n3_wm == 23'd0) begin
                n3_wid = {r2_data[31], 63'd0};
            end else begin
                n3_wid = {r2_data[31], 11'd897 - {6'd0, r2_c}, 23'(n3_wm << r2_c), 29'd0};
            end
        end else begin
            n3_wid = {r2_data[31], {3'd0, n3_we} + 11'd896, n3_wm, 29'd0};
        end

        case (r2_fmt)
            pcmfc_pkg::FMT_F32:  n3_dec = n3_wid;
            pcmfc_pkg::FMT_F64:  n3_dec = r2_data;
            pcmfc_pkg::FMT_NONE: n3_dec = '0;
            default:             n3_dec = n3_int;
        endcase

        n3_top = 7'd52 + {2'd0, r2_n};
        n3_d   = r2_p[n3_top] ? r2_n : (r2_n - 5'd1);
        n3_ps  = r2_p >> n3_d;
        n3_low = (84'd1 << (n3_d - 5'd1)) - 84'd1;
        n3_rnd = r2_p[n3_d - 5'd1] && ((|(r2_p & n3_low)) || r2_p[n3_d]);
        n3_rk  = n3_ps[53:0] + {53'd0, n3_rnd};

        n3_m54 = {1'b0, r2_m};
        if (r2_e >= 11'd897) begin
            n3_fbase = {8'(r2_e - 11'd896), r2_m[51:29]};
            n3_frnd  = r2_m[28] && ((|r2_m[27:0]) || r2_m[29]);
            n3_fw    = n3_fbase + {30'd0, n3_frnd};
            n3_fs    = '0;
            n3_s6    = '0;
            n3_fsm   = '0;
            n3_flow  = '0;
        end else begin
            n3_fbase = '0;
            n3_fs    = 11'd926 - r2_e;
            n3_s6    = n3_fs[5:0];
            n3_fsm   = n3_m54 >> n3_s6;
            n3_flow  = (54'd1 << (n3_s6 - 6'd1)) - 54'd1;
            n3_frnd  = n3_m54[n3_s6 - 6'd1] && ((|(n3_m54 & n3_flow)) || n3_fsm[0]);
            if (n3_fs >= 11'd55) begin
                n3_fw = '0;
            end else begin
                n3_fw = n3_fsm[30:0] + {30'd0, n3_frnd};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_v <= 1'b0;
        end else if (en3) begin
            r3_v <= r2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en3) begin
            r3_req  <= r2_req;
            r3_fmt  <= r2_fmt;
            r3_data <= r2_data;
            r3_dec  <= n3_dec;
            r3_sgn  <= r2_sgn;
            r3_nan  <= r2_nan;
            r3_zero <= (r2_e == 11'd0);
            r3_rk   <= n3_rk;
            r3_sh   <= 12'd1075 - {1'b0, r2_e} - {7'd0, n3_d};
            r3_f32  <= {r2_sgn, n3_fw};
        end
    end

    // Stage 4: truncate toward zero, apply the sign and pack the bytes.
    logic [53:0] n4_q;
    logic [31:0] n4_qs;
    logic [63:0] n4_bytes;

    always_comb begin
        if (r3_zero || (r3_sh >= 12'd54)) begin
            n4_q = '0;
        end else begin
            n4_q = r3_rk >> r3_sh[5:0];
        end
        n4_qs = r3_sgn ? (32'd0 - n4_q[31:0]) : n4_q[31:0];
        case (r3_fmt)
            pcmfc_pkg::FMT_S16:    n4_bytes = {48'd0, n4_qs[15:0]};
            pcmfc_pkg::FMT_S24_3:  n4_bytes = {40'd0, n4_qs[23:0]};
            pcmfc_pkg::FMT_S24_RJ: n4_bytes = {32'd0, {8{n4_qs[23]}}, n4_qs[23:0]};
            pcmfc_pkg::FMT_S24_LJ: n4_bytes = {32'd0, n4_qs[23:0], 8'd0};
            pcmfc_pkg::FMT_S32:    n4_bytes = {32'd0, n4_qs};
            pcmfc_pkg::FMT_F32:    n4_bytes = {32'd0, r3_f32};
            pcmfc_pkg::FMT_F64:    n4_bytes = r3_data;
            default:               n4_bytes = '0;
        endcase
        if (r3_nan) begin
            n4_bytes = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_v <= 1'b0;
        end else if (en4) begin
            r4_v <= r3_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en4) begin
            r4_req       <= r3_req;
            r_out_value  <= (r3_req == pcmfc_pkg::REQ_DECODE) ? r3_dec : 64'd0;
            r_out_bytes  <= (r3_req == pcmfc_pkg::REQ_DECODE) ? 64'd0 : n4_bytes;
            r_byte_count <= pcmfc_pkg::fmt_size(r3_fmt);
        end
    end

    assign o_valid      = r4_v;
    assign o_out_value  = r_out_value;
    assign o_out_bytes  = r_out_bytes;
    assign o_byte_count = r_byte_count;

    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (r1_v && r2_v && r3_v && r4_v))
        else $error("input stalled while the pipeline has a free stage");

    a_accept_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> r1_v)
        else $error("accepted word did not enter the first stage");

    a_decode_no_bytes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (r4_req == pcmfc_pkg::REQ_DECODE)) |-> (o_out_bytes == 64'd0))
        else $error("decode result carries encoded bytes");

    a_none_is_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_byte_count == 4'd0)) |-> (o_out_value == 64'd0 && o_out_bytes == 64'd0))
        else $error("unused format code gave a nonzero result");

endmodule
